### hdl/cfsp_pkg.sv
// Shared types, constants and the CRC-16/CCITT-FALSE byte step for the
// framed stream parser. No dependencies; used by every module under hdl.
package cfsp_pkg;

  // Frame geometry
  localparam int MAX_PAYLOAD = 32;
  localparam int MAX_FRAME   = 43;
  localparam int PAY_AW      = $clog2(MAX_PAYLOAD);
  localparam int CNT_W       = $clog2(MAX_FRAME + 1);
  localparam int LEN_POS     = 8;    // offset of the length byte
  localparam int HDR_LEN     = 9;    // sync through length
  localparam int OVERHEAD    = 11;   // header plus two CRC bytes
  localparam int TRAIL_LEN   = 2;

  // Fixed field widths
  localparam int LEN_W  = 6;
  localparam int POS_W  = 5;
  localparam int STAT_W = 3;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  typedef enum logic [STAT_W-1:0] {
    ST_NONE    = 3'd0,
    ST_FRAME   = 3'd1,
    ST_VERSION = 3'd2,
    ST_LENGTH  = 3'd3,
    ST_CRC     = 3'd4,
    ST_TIMEOUT = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    CFG_SYNC_FIRST  = 2'd0,
    CFG_SYNC_SECOND = 2'd1,
    CFG_VERSION     = 2'd2,
    CFG_TIMEOUT     = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE     = 2'd0,
    S_EMIT_RD  = 2'd1,
    S_EMIT_OUT = 2'd2
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic take;         // apply the accepted request to the parse state
    logic load_single;  // load the one-result answer into the output register
    logic emit_start;   // rewind the payload read pointer
    logic emit_load;    // load a payload result into the output register
    logic emit_next;    // advance the payload read pointer
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;     // output register empty or being taken
    logic frame_multi;  // current request completes a frame with payload
    logic emit_last;    // read pointer is at the final payload byte
  } dp_stat_t;

  // One byte of CRC-16/CCITT-FALSE, MSB first
  function automatic logic [15:0] crc_step(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### hdl/cfsp_ctrl.sv
// Controller state machine: accepts requests and sequences payload results.
// Depends on cfsp_pkg for the state, command and status types.
module cfsp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  cfsp_pkg::dp_stat_t  stat,
  output cfsp_pkg::ctrl_cmd_t cmd
);

  cfsp_pkg::state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cfsp_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      cfsp_pkg::S_IDLE: begin
        in_tready = stat.out_free;
        if (in_tvalid && stat.out_free) begin
          cmd.take = 1'b1;
          if (stat.frame_multi) begin
            cmd.emit_start = 1'b1;
            state_nxt      = cfsp_pkg::S_EMIT_RD;
          end else begin
            cmd.load_single = 1'b1;
          end
        end
      end
      cfsp_pkg::S_EMIT_RD: begin
        state_nxt = cfsp_pkg::S_EMIT_OUT;
      end
      cfsp_pkg::S_EMIT_OUT: begin
        if (stat.out_free) begin
          cmd.emit_load = 1'b1;
          if (stat.emit_last) begin
            state_nxt = cfsp_pkg::S_IDLE;
          end else begin
            cmd.emit_next = 1'b1;
            state_nxt     = cfsp_pkg::S_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = cfsp_pkg::S_IDLE;
      end
    endcase
  end

endmodule

### hdl/cfsp_dp.sv
// Datapath: configuration registers, parse state, CRC, header registers,
// payload memory and the output register. Depends on cfsp_pkg.
module cfsp_dp (
  input  logic                clk,
  input  logic                rst_n,
  // configuration
  input  logic                cfg_valid,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  // request fields
  input  logic                in_func,
  input  logic [7:0]          in_byte,
  input  logic [31:0]         in_now,
  // control
  input  cfsp_pkg::ctrl_cmd_t cmd,
  output cfsp_pkg::dp_stat_t  stat,
  // result
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [71:0]         out_tdata,
  output logic [2:0]          out_tuser,
  output logic                out_tlast
);

  localparam int CW = cfsp_pkg::CNT_W;

  // Configuration registers
  logic [7:0]  sync_first_r, sync_second_r, version_cfg_r;
  logic [15:0] timeout_r;

  // Parse state
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] exp_r, exp_nxt;
  logic [15:0]   crc_r, crc_nxt;
  logic [31:0]   last_time_r;

  // Captured frame bytes
  logic [7:0] ver_r, type_r, src_r, dst_r, seq_r, flags_r, crc_hi_r;
  logic [cfsp_pkg::LEN_W-1:0] len_r;

  // Payload memory
  logic [7:0] pay_mem [cfsp_pkg::MAX_PAYLOAD];
  logic [7:0] rd_data_r;
  logic [cfsp_pkg::PAY_AW-1:0] emit_pos_r;
  logic       mem_we;
  logic [cfsp_pkg::PAY_AW-1:0] mem_waddr;

  // Output register
  logic        out_valid_r;
  logic [71:0] out_data_r;
  logic [2:0]  out_stat_r;
  logic        out_last_r;

  // Request decode
  cfsp_pkg::status_t res_code;
  logic        frame_ok;
  logic        hit_sync;
  logic [CW:0] pos_p2;
  logic        in_payload, at_crc_hi, crc_upd;
  logic [31:0] elapsed;
  logic [CW-1:0] cnt_inc;

  // Write configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= 8'hAA;
      sync_second_r <= 8'h55;
      version_cfg_r <= 8'h22;
      timeout_r     <= 16'd100;
    end else if (cfg_valid) begin
      case (cfsp_pkg::cfg_idx_t'(cfg_index))
        cfsp_pkg::CFG_SYNC_FIRST:  sync_first_r  <= cfg_data[7:0];
        cfsp_pkg::CFG_SYNC_SECOND: sync_second_r <= cfg_data[7:0];
        cfsp_pkg::CFG_VERSION:     version_cfg_r <= cfg_data[7:0];
        cfsp_pkg::CFG_TIMEOUT:     timeout_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Classify the request and form the next parse state
  always_comb begin
    hit_sync   = (in_byte == sync_first_r);
    cnt_inc    = cnt_r + CW'(1);
    pos_p2     = {1'b0, cnt_r} + (CW+1)'(cfsp_pkg::TRAIL_LEN);
    in_payload = (exp_r != '0) && (pos_p2 < {1'b0, exp_r});
    at_crc_hi  = (exp_r != '0) && (pos_p2 == {1'b0, exp_r});
    crc_upd    = (cnt_r < CW'(cfsp_pkg::HDR_LEN)) || in_payload;
    elapsed    = in_now - last_time_r;
    mem_we     = 1'b0;
    mem_waddr  = cfsp_pkg::PAY_AW'(cnt_r - CW'(cfsp_pkg::HDR_LEN));
    res_code   = cfsp_pkg::ST_NONE;
    frame_ok   = 1'b0;
    cnt_nxt    = cnt_r;
    exp_nxt    = exp_r;
    crc_nxt    = crc_r;

    if (in_func) begin
      // timeout check drops a stale partial frame
      if (cnt_r != '0 && elapsed > {16'h0000, timeout_r}) begin
        res_code = cfsp_pkg::ST_TIMEOUT;
        cnt_nxt  = '0;
        exp_nxt  = '0;
        crc_nxt  = cfsp_pkg::CRC_INIT;
      end
    end else if (cnt_r == '0) begin
      if (hit_sync) begin
        cnt_nxt = CW'(1);
        crc_nxt = cfsp_pkg::CRC_INIT;
      end
    end else if (cnt_r == CW'(1)) begin
      cnt_nxt = (in_byte == sync_second_r) ? CW'(2) : (hit_sync ? CW'(1) : '0);
      exp_nxt = '0;
      crc_nxt = cfsp_pkg::CRC_INIT;
    end else if (cnt_r >= CW'(cfsp_pkg::MAX_FRAME)) begin
      res_code = cfsp_pkg::ST_LENGTH;
    end else begin
      cnt_nxt = cnt_inc;
      if (crc_upd) begin
        crc_nxt = cfsp_pkg::crc_step(crc_r, in_byte);
      end
      mem_we = (cnt_r >= CW'(cfsp_pkg::HDR_LEN)) && in_payload;
      if (cnt_r == CW'(cfsp_pkg::LEN_POS)) begin
        if (ver_r != version_cfg_r) begin
          res_code = cfsp_pkg::ST_VERSION;
        end else if (in_byte > 8'(cfsp_pkg::MAX_PAYLOAD)) begin
          res_code = cfsp_pkg::ST_LENGTH;
        end else begin
          exp_nxt = CW'(in_byte) + CW'(cfsp_pkg::OVERHEAD);
        end
      end else if (exp_r != '0 && cnt_inc == exp_r) begin
        if ({crc_hi_r, in_byte} != crc_r) begin
          res_code = cfsp_pkg::ST_CRC;
        end else begin
          res_code = cfsp_pkg::ST_FRAME;
          frame_ok = 1'b1;
          cnt_nxt  = '0;
          exp_nxt  = '0;
          crc_nxt  = cfsp_pkg::CRC_INIT;
        end
      end
    end

    // restart the hunt after an error on a received byte
    if (!in_func && (res_code == cfsp_pkg::ST_VERSION || res_code == cfsp_pkg::ST_LENGTH ||
                     res_code == cfsp_pkg::ST_CRC)) begin
      cnt_nxt = hit_sync ? CW'(1) : '0;
      exp_nxt = '0;
      crc_nxt = cfsp_pkg::CRC_INIT;
    end
  end

  // Parse state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      exp_r       <= '0;
      crc_r       <= cfsp_pkg::CRC_INIT;
      last_time_r <= '0;
    end else if (cmd.take) begin
      cnt_r <= cnt_nxt;
      exp_r <= exp_nxt;
      crc_r <= crc_nxt;
      if (!in_func) begin
        last_time_r <= in_now;
      end
    end
  end

  // Capture header and CRC high byte
  always_ff @(posedge clk) begin
    if (cmd.take && !in_func && cnt_r >= CW'(2) && cnt_r < CW'(cfsp_pkg::MAX_FRAME)) begin
      case (cnt_r)
        CW'(2): ver_r   <= in_byte;
        CW'(3): type_r  <= in_byte;
        CW'(4): src_r   <= in_byte;
        CW'(5): dst_r   <= in_byte;
        CW'(6): seq_r   <= in_byte;
        CW'(7): flags_r <= in_byte;
        CW'(cfsp_pkg::LEN_POS): len_r <= in_byte[cfsp_pkg::LEN_W-1:0];
        default: begin
          if (at_crc_hi) begin
            crc_hi_r <= in_byte;
          end
        end
      endcase
    end
  end

  // Payload memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.take && !in_func && mem_we) begin
      pay_mem[mem_waddr] <= in_byte;
    end
    rd_data_r <= pay_mem[emit_pos_r];
  end

  // Payload read pointer
  always_ff @(posedge clk) begin
    if (cmd.emit_start) begin
      emit_pos_r <= '0;
    end else if (cmd.emit_next) begin
      emit_pos_r <= emit_pos_r + cfsp_pkg::PAY_AW'(1);
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_single || cmd.emit_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (cmd.load_single) begin
      out_stat_r <= res_code;
      out_last_r <= 1'b1;
      if (frame_ok) begin
        out_data_r <= {5'd0, cfsp_pkg::POS_W'(0), 8'h00, len_r,
                       flags_r, seq_r, dst_r, src_r, type_r, ver_r};
      end else begin
        out_data_r <= '0;
      end
    end else if (cmd.emit_load) begin
      out_stat_r <= cfsp_pkg::ST_FRAME;
      out_last_r <= stat.emit_last;
      out_data_r <= {5'd0, cfsp_pkg::POS_W'(emit_pos_r), rd_data_r, len_r,
                     flags_r, seq_r, dst_r, src_r, type_r, ver_r};
    end
  end

  // Status to the controller
  always_comb begin
    stat.out_free    = !out_valid_r || out_tready;
    stat.frame_multi = frame_ok && (len_r != '0);
    stat.emit_last   = ((cfsp_pkg::LEN_W)'(emit_pos_r) + (cfsp_pkg::LEN_W)'(1)) == len_r;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_stat_r;
  assign out_tlast  = out_last_r;

endmodule

### hdl/crc16_frame_stream_parser.sv
// Framed packet parser with CRC-16/CCITT-FALSE check. Each request (a
// received byte or a timeout check, in_tuser = 1) answers with one result,
// except a good frame with L > 0 payload bytes, which answers with L
// results; those are read from the payload memory and leave one at a time
// (memory read, then the output register), and no new request is taken
// until the last one is loaded. A request is taken only when the output
// register is empty or its result leaves in the same cycle, so a result
// held by out_tready also holds in_tready low.
// Configuration writes are always ready and must only be made while idle.
// Top level; instantiates cfsp_ctrl and cfsp_dp, uses cfsp_pkg.
module crc16_frame_stream_parser (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // requests
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [7:0] data_byte, [39:8] now_ms
  input  logic        in_tuser,   // [0] func
  // results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [7:0] frame_version, [15:8] frame_type,
                                  // [23:16] source_addr, [31:24] dest_addr,
                                  // [39:32] sequence_num, [47:40] flags_byte,
                                  // [53:48] payload_length, [61:54] payload_byte,
                                  // [66:62] payload_pos, [71:67] zero
  output logic [2:0]  out_tuser,  // [2:0] status
  output logic        out_tlast   // last_of_run
);

  cfsp_pkg::ctrl_cmd_t cmd;
  cfsp_pkg::dp_stat_t  stat;

  assign cfg_ready = 1'b1;

  cfsp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cfsp_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_func    (in_tuser),
    .in_byte    (in_tdata[7:0]),
    .in_now     (in_tdata[39:8]),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

### verif/tb.sv
// Self-checking testbench for crc16_frame_stream_parser: drives received bytes and
// timeout checks, predicts every result and compares it field by field.
// Depends on hdl/cfsp_pkg.sv and hdl/crc16_frame_stream_parser.sv.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HEADER_BYTES    = 9;   // sync through length byte
  localparam int FRAME_OVERHEAD  = 11;  // header plus two CRC bytes
  localparam int ITEMS_PER_PHASE = 22;
  localparam int NUM_PHASES      = 5;
  localparam int SETTLE_CYCLES   = 2 * cfsp_pkg::MAX_PAYLOAD + 8;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int MAX_PRINTED     = 40;
  localparam logic [15:0] CRC_SEED = 16'hFFFF;
  localparam logic [15:0] CRC_GEN  = 16'h1021;

  typedef struct {
    logic [2:0] status;
    logic [7:0] version;
    logic [7:0] frm_type;
    logic [7:0] src_addr;
    logic [7:0] dst_addr;
    logic [7:0] seq_num;
    logic [7:0] flags;
    logic [5:0] plen;
    logic [7:0] pbyte;
    logic [4:0] ppos;
    logic       last;
  } parse_result_t;

  // Frame parser predictor plus the queue of results it still owes
  class frame_scoreboard;
    bit [7:0]  sync_a;
    bit [7:0]  sync_b;
    bit [7:0]  ver_req;
    bit [15:0] timeout_limit;
    bit [7:0]  frame_bytes[cfsp_pkg::MAX_FRAME];
    bit [7:0]  byte_count;
    bit [7:0]  frame_total;
    bit [15:0] crc_acc;
    bit [31:0] last_rx_ms;
    parse_result_t result_q[$];
    int mismatches;
    int checked;
    int status_seen[6];

    function new();
      sync_a        = 8'hAA;
      sync_b        = 8'h55;
      ver_req       = 8'h22;
      timeout_limit = 16'd100;
      byte_count    = 0;
      frame_total   = 0;
      crc_acc       = CRC_SEED;
      last_rx_ms    = 0;
      mismatches    = 0;
      checked       = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    // Bit-serial CRC-16/CCITT-FALSE, MSB first
    function bit [15:0] crc_update(bit [15:0] crc, bit [7:0] b);
      bit fb;
      for (int i = 7; i >= 0; i--) begin
        fb  = crc[15] ^ b[i];
        crc = {crc[14:0], 1'b0};
        if (fb) begin
          crc = crc ^ CRC_GEN;
        end
      end
      return crc;
    endfunction

    function void write_reg(cfsp_pkg::cfg_idx_t idx, bit [15:0] val);
      case (idx)
        cfsp_pkg::CFG_SYNC_FIRST:  sync_a        = val[7:0];
        cfsp_pkg::CFG_SYNC_SECOND: sync_b        = val[7:0];
        cfsp_pkg::CFG_VERSION:     ver_req       = val[7:0];
        cfsp_pkg::CFG_TIMEOUT:     timeout_limit = val;
        default: ;
      endcase
    endfunction

    function void push_single(cfsp_pkg::status_t st);
      parse_result_t r;
      r = '{status: st, version: 0, frm_type: 0, src_addr: 0, dst_addr: 0, seq_num: 0,
            flags: 0, plen: 0, pbyte: 0, ppos: 0, last: 1'b1};
      result_q.push_back(r);
    endfunction

    function void clear_frame();
      byte_count  = 0;
      frame_total = 0;
      crc_acc     = CRC_SEED;
    endfunction

    // Drop the partial frame; keep the offending byte if it can start a new one
    function void restart_hunt(bit [7:0] b);
      clear_frame();
      if (b == sync_a) begin
        frame_bytes[0] = b;
        byte_count     = 1;
      end
    endfunction

    function void emit_frame();
      parse_result_t r;
      int len;
      int n;
      len = frame_bytes[8];
      n   = (len == 0) ? 1 : len;
      for (int i = 0; i < n; i++) begin
        r.status   = cfsp_pkg::ST_FRAME;
        r.version  = frame_bytes[2];
        r.frm_type = frame_bytes[3];
        r.src_addr = frame_bytes[4];
        r.dst_addr = frame_bytes[5];
        r.seq_num  = frame_bytes[6];
        r.flags    = frame_bytes[7];
        r.plen     = len[5:0];
        r.pbyte    = (len == 0) ? 8'd0 : frame_bytes[HEADER_BYTES + i];
        r.ppos     = (len == 0) ? 5'd0 : i[4:0];
        r.last     = (i + 1 == n);
        result_q.push_back(r);
      end
      clear_frame();
    endfunction

    function void take_byte(bit [7:0] b);
      int pos;
      int len;
      bit [15:0] rx_crc;
      // hunt for the two sync bytes
      if (byte_count == 0) begin
        if (b == sync_a) begin
          frame_bytes[0] = b;
          byte_count     = 1;
          crc_acc        = CRC_SEED;
        end
        push_single(cfsp_pkg::ST_NONE);
        return;
      end
      if (byte_count == 1) begin
        if (b == sync_b) begin
          frame_bytes[1] = b;
          byte_count     = 2;
          crc_acc        = CRC_SEED;
        end else begin
          restart_hunt(b);
        end
        push_single(cfsp_pkg::ST_NONE);
        return;
      end
      if (byte_count >= cfsp_pkg::MAX_FRAME) begin
        restart_hunt(b);
        push_single(cfsp_pkg::ST_LENGTH);
        return;
      end
      // store the byte and fold it into the CRC unless it is a CRC byte
      pos              = byte_count;
      frame_bytes[pos] = b;
      byte_count       = 8'(pos + 1);
      if (pos < HEADER_BYTES || (frame_total != 0 && pos + 2 < frame_total)) begin
        crc_acc = crc_update(crc_acc, b);
      end
      // header complete: check version and length
      if (byte_count == HEADER_BYTES) begin
        if (frame_bytes[2] != ver_req) begin
          restart_hunt(b);
          push_single(cfsp_pkg::ST_VERSION);
          return;
        end
        if (frame_bytes[8] > cfsp_pkg::MAX_PAYLOAD) begin
          restart_hunt(b);
          push_single(cfsp_pkg::ST_LENGTH);
          return;
        end
        frame_total = 8'(FRAME_OVERHEAD + frame_bytes[8]);
      end
      // whole frame in: compare the big-endian CRC
      if (frame_total != 0 && byte_count == frame_total) begin
        len    = frame_bytes[8];
        rx_crc = {frame_bytes[HEADER_BYTES + len], frame_bytes[HEADER_BYTES + 1 + len]};
        if (rx_crc != crc_acc) begin
          restart_hunt(b);
          push_single(cfsp_pkg::ST_CRC);
        end else begin
          emit_frame();
        end
        return;
      end
      push_single(cfsp_pkg::ST_NONE);
    endfunction

    function void note_request(bit func, bit [7:0] b, bit [31:0] now);
      bit [31:0] idle_ms;
      if (func) begin
        idle_ms = now - last_rx_ms;
        if (byte_count == 0 || idle_ms <= {16'd0, timeout_limit}) begin
          push_single(cfsp_pkg::ST_NONE);
        end else begin
          clear_frame();
          push_single(cfsp_pkg::ST_TIMEOUT);
        end
        return;
      end
      last_rx_ms = now;
      take_byte(b);
    endfunction

    task log_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTED) begin
        $display("[%0t] MISMATCH result %0d: %s", $realtime, checked, msg);
      end
    endtask

    task cmp_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want) begin
        log_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
      end
    endtask

    task check_result(logic [2:0] st, logic [71:0] d, logic last);
      parse_result_t want;
      if (result_q.size() == 0) begin
        log_mismatch($sformatf("unrequested result, status %0d", st));
        return;
      end
      want = result_q.pop_front();
      cmp_field("status", {5'd0, st}, {5'd0, want.status});
      cmp_field("frame_version", d[7:0], want.version);
      cmp_field("frame_type", d[15:8], want.frm_type);
      cmp_field("source_addr", d[23:16], want.src_addr);
      cmp_field("dest_addr", d[31:24], want.dst_addr);
      cmp_field("sequence_num", d[39:32], want.seq_num);
      cmp_field("flags_byte", d[47:40], want.flags);
      cmp_field("payload_length", {2'd0, d[53:48]}, {2'd0, want.plen});
      cmp_field("payload_byte", d[61:54], want.pbyte);
      cmp_field("payload_pos", {3'd0, d[66:62]}, {3'd0, want.ppos});
      cmp_field("last_of_run", {7'd0, last}, {7'd0, want.last});
      if (want.status < 6) begin
        status_seen[want.status]++;
      end
      checked++;
    endtask

    task flush_leftovers();
      while (result_q.size() != 0) begin
        log_mismatch($sformatf("result never produced, status %0d", result_q[0].status));
        void'(result_q.pop_front());
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;   // [7:0] data_byte, [39:8] now_ms
  logic        in_tuser = 1'b0; // [0] func
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;       // [7:0] version ... [66:62] payload_pos, [71:67] zero
  logic [2:0]  out_tuser;       // [2:0] status
  logic        out_tlast;

  frame_scoreboard sb = new();
  int        send_idle_pct = 0;
  int        stall_pct = 0;
  int        requests_sent = 0;
  int        quiet_cycles = 0;
  bit [31:0] ms_clock = 32'hFFFF_FFFA;

  crc16_frame_stream_parser DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Random backpressure on the result side
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Check every accepted result
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tuser, out_tdata, out_tlast);
    end
  end

  // End the run if nothing moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(bit func, bit [7:0] b, bit [31:0] now);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {now, b};
    in_tuser  = func;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(func, b, now);
    requests_sent++;
  endtask

  task automatic send_byte(bit [7:0] b);
    if ($urandom_range(0, 49) == 0) begin
      ms_clock = $urandom();
    end else begin
      ms_clock = ms_clock + $urandom_range(0, 3);
    end
    send_request(1'b0, b, ms_clock);
  endtask

  // Timeout check at a given distance from the last received byte
  task automatic send_check(bit [31:0] delta);
    ms_clock = sb.last_rx_ms + delta;
    send_request(1'b1, 8'($urandom()), ms_clock);
  endtask

  task automatic send_random_check();
    bit [31:0] lim;
    lim = {16'd0, sb.timeout_limit};
    case ($urandom_range(0, 3))
      0: send_check($urandom_range(0, 2));
      1: send_check(lim);
      2: send_check(lim + 1);
      default: send_check(lim + 1 + $urandom_range(0, 1000));
    endcase
  endtask

  // Hold the sender until every predicted result has come out
  task automatic wait_results_done();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (sb.result_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfsp_pkg::cfg_idx_t idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic apply_settings(bit [7:0] s1, bit [7:0] s2, bit [7:0] ver, bit [15:0] tmo);
    write_reg(cfsp_pkg::CFG_SYNC_FIRST, {8'd0, s1});
    write_reg(cfsp_pkg::CFG_SYNC_SECOND, {8'd0, s2});
    write_reg(cfsp_pkg::CFG_VERSION, {8'd0, ver});
    write_reg(cfsp_pkg::CFG_TIMEOUT, tmo);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Build a frame with random content; sometimes a bad version, length or CRC
  task automatic send_frame();
    bit [7:0]  frm[$];
    bit [15:0] crc;
    int        plen;
    int        pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      plen = cfsp_pkg::MAX_PAYLOAD;
    end else if (pick < 16) begin
      plen = $urandom_range(cfsp_pkg::MAX_PAYLOAD + 1, 255);
    end else begin
      plen = $urandom_range(0, 6);
    end
    frm.push_back(sb.sync_a);
    frm.push_back(sb.sync_b);
    frm.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom()) : sb.ver_req);
    for (int i = 0; i < 5; i++) frm.push_back(8'($urandom()));
    frm.push_back(plen[7:0]);
    if (plen <= cfsp_pkg::MAX_PAYLOAD) begin
      for (int i = 0; i < plen; i++) frm.push_back(8'($urandom()));
      crc = CRC_SEED;
      for (int i = 2; i < frm.size(); i++) crc = sb.crc_update(crc, frm[i]);
      if ($urandom_range(0, 9) == 0) begin
        crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
      end
      frm.push_back(crc[15:8]);
      frm.push_back(crc[7:0]);
    end
    foreach (frm[i]) begin
      if ($urandom_range(0, 39) == 0) begin
        send_random_check();
      end
      if ($urandom_range(0, 59) == 0) begin
        wait_results_done();
      end
      send_byte(frm[i]);
    end
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++) begin
      send_byte(($urandom_range(0, 3) == 0) ? sb.sync_a : 8'($urandom()));
    end
  endtask

  task automatic run_traffic(int n_items);
    int start;
    int pick;
    start = requests_sent;
    while (requests_sent - start < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_frame();
      end else if (pick < 85) begin
        send_noise();
      end else begin
        send_random_check();
      end
    end
  endtask

  // Directed opening with reset settings: empty check, empty-payload frame
  // across the timestamp wrap, sync-first restart, timeout boundary, and an
  // oversize length byte that equals the first sync byte
  task automatic run_directed();
    bit [7:0]  frm[$];
    bit [15:0] crc;
    send_request(1'b1, 8'h00, 32'd5000);
    frm = {sb.sync_a, sb.sync_b, sb.ver_req, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00};
    crc = CRC_SEED;
    for (int i = 2; i < frm.size(); i++) crc = sb.crc_update(crc, frm[i]);
    frm.push_back(crc[15:8]);
    frm.push_back(crc[7:0]);
    foreach (frm[i]) send_byte(frm[i]);
    send_byte(sb.sync_a);
    send_byte(sb.sync_a);
    send_check({16'd0, sb.timeout_limit});
    send_check({16'd0, sb.timeout_limit} + 1);
    frm = {sb.sync_a, sb.sync_b, sb.ver_req, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, sb.sync_a};
    foreach (frm[i]) send_byte(frm[i]);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        wait_results_done();
        repeat (SETTLE_CYCLES) @(posedge clk);
      end
      case (p)
        1: apply_settings(8'h00, 8'hFF, 8'h00, 16'd0);
        2: apply_settings(8'hFF, 8'h00, 8'hFF, 16'hFFFF);
        3, 4: apply_settings(8'($urandom()), 8'($urandom()), 8'($urandom()),
                             16'($urandom_range(0, 300)));
        default: ;
      endcase
      send_idle_pct = (p == 1) ? 62 : (p == 3) ? 29 : 0;
      stall_pct     = (p == 2) ? 62 : (p == 3) ? 29 : 0;
      if (p == 0) begin
        run_directed();
      end
      run_traffic(ITEMS_PER_PHASE);
    end

    wait_results_done();
    repeat (SETTLE_CYCLES) @(posedge clk);
    sb.flush_leftovers();

    $display("Run: %0d requests over %0d register settings, %0d results checked",
             requests_sent, NUM_PHASES, sb.checked);
    $display("Seen: %0d frame, %0d version err, %0d length err, %0d crc err, %0d timeout",
             sb.status_seen[cfsp_pkg::ST_FRAME], sb.status_seen[cfsp_pkg::ST_VERSION],
             sb.status_seen[cfsp_pkg::ST_LENGTH], sb.status_seen[cfsp_pkg::ST_CRC],
             sb.status_seen[cfsp_pkg::ST_TIMEOUT]);
    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
